>>> rtl/core/rme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_pkg
// shared constants for the rotation matrix to euler angle pipeline
// ----------------------------------------------------------------------------
package rme_pkg;

  localparam int ANGLE_W     = 35;
  localparam int TABLE_LEN   = 24;
  localparam int PRESHIFT    = 14;
  localparam int ROUND_SHIFT = 17;
  localparam int THR_W       = 15;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [ADDR_W-1:0] ADDR_THRESHOLD = 3'd0;
  localparam logic [THR_W-1:0]  THR_RESET      = 15'd1;

  localparam int PI_Q13      = 25736;
  localparam int HALF_PI_Q13 = 12868;

  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [ANGLE_W-1:0] ROUND_Q30   = 35'sd65536;

  localparam logic signed [ANGLE_W-1:0] ATAN_Q30 [TABLE_LEN] = '{
    35'sd843314856, 35'sd497837829, 35'sd263043836, 35'sd133525158,
    35'sd67021686,  35'sd33543515,  35'sd16775850,  35'sd8388437,
    35'sd4194282,   35'sd2097149,   35'sd1048575,   35'sd524287,
    35'sd262143,    35'sd131071,    35'sd65535,     35'sd32767,
    35'sd16383,     35'sd8191,      35'sd4095,      35'sd2047,
    35'sd1023,      35'sd511,       35'sd255,       35'sd127
  };

endpackage

>>> rtl/core/rme_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_isqrt
// pipelined integer square root, one root bit per stage, with a valid bit
// and a sideband word carried alongside
// ----------------------------------------------------------------------------
module rme_isqrt #(
  parameter int IN_W   = 32,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   in_n,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [IN_W/2-1:0] out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int H  = IN_W / 2;
  localparam int RW = H + 2;

  logic              v_r    [H];
  logic [H-1:0]      root_r [H];
  logic [SIDE_W-1:0] side_r [H];
  logic [RW-1:0]     rem_r  [H-1];
  logic [IN_W-1:0]   n_r    [H-1];

  for (genvar k = 0; k < H; k++) begin : g_stage
    logic              v_in;
    logic [RW-1:0]     rem_in;
    logic [H-1:0]      root_in;
    logic [IN_W-1:0]   n_in;
    logic [SIDE_W-1:0] side_in;
    logic [RW-1:0]     cur;
    logic [RW-1:0]     trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = in_n;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign n_in    = n_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign cur   = {rem_in[RW-3:0], n_in[IN_W-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      root_r[k] <= {root_in[H-2:0], ge};
      side_r[k] <= side_in;
    end

    if (k < H - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_r[k] <= ge ? (cur - trial) : cur;
        n_r[k]   <= {n_in[IN_W-3:0], 2'b00};
      end
    end
  end

  assign out_valid = v_r[H-1];
  assign out_root  = root_r[H-1];
  assign out_side  = side_r[H-1];

endmodule

>>> rtl/core/rme_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_cordic
// pipelined vectoring atan2: quadrant fold, one micro-rotation per stage,
// then rounding to q3.13 and saturation
// ----------------------------------------------------------------------------
module rme_cordic #(
  parameter int IW    = 18,
  parameter int STEPS = 16,
  parameter int OW    = 16,
  parameter int LIM   = 25736
) (
  input  logic                 clk,
  input  logic signed [IW-1:0] in_y,
  input  logic signed [IW-1:0] in_x,
  input  logic                 in_force_zero,
  output logic signed [OW-1:0] out_angle
);

  localparam int W  = IW + rme_pkg::PRESHIFT + 3;
  localparam int AW = rme_pkg::ANGLE_W;
  localparam int QW = AW - rme_pkg::ROUND_SHIFT;
  localparam logic signed [QW-1:0] LIM_Q = QW'(LIM);

  logic signed [W-1:0]  xs;
  logic signed [W-1:0]  ys;
  logic signed [W-1:0]  x_pre_nxt;
  logic signed [W-1:0]  y_pre_nxt;
  logic signed [AW-1:0] a_pre_nxt;
  logic                 z_pre_nxt;

  logic signed [W-1:0]  x_pre_r;
  logic signed [W-1:0]  y_pre_r;
  logic signed [AW-1:0] a_pre_r;
  logic                 z_pre_r;

  logic signed [W-1:0]  x_r [STEPS];
  logic signed [W-1:0]  y_r [STEPS];
  logic signed [AW-1:0] a_r [STEPS];
  logic                 z_r [STEPS];

  logic signed [AW-1:0] a_sum;
  logic signed [QW-1:0] q;
  logic signed [QW-1:0] q_sat;
  logic signed [OW-1:0] out_r;

  assign xs = W'(in_x) <<< rme_pkg::PRESHIFT;
  assign ys = W'(in_y) <<< rme_pkg::PRESHIFT;

  always_comb begin
    z_pre_nxt = in_force_zero || ((in_x == '0) && (in_y == '0));
    if (xs[W-1] && !ys[W-1]) begin
      x_pre_nxt = ys;
      y_pre_nxt = -xs;
      a_pre_nxt = rme_pkg::HALF_PI_Q30;
    end else if (xs[W-1]) begin
      x_pre_nxt = -ys;
      y_pre_nxt = xs;
      a_pre_nxt = -rme_pkg::HALF_PI_Q30;
    end else begin
      x_pre_nxt = xs;
      y_pre_nxt = ys;
      a_pre_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    x_pre_r <= x_pre_nxt;
    y_pre_r <= y_pre_nxt;
    a_pre_r <= a_pre_nxt;
    z_pre_r <= z_pre_nxt;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    logic signed [W-1:0]  x_in;
    logic signed [W-1:0]  y_in;
    logic signed [AW-1:0] a_in;
    logic                 z_in;
    logic signed [W-1:0]  dx;
    logic signed [W-1:0]  dy;

    if (i == 0) begin : g_first
      assign x_in = x_pre_r;
      assign y_in = y_pre_r;
      assign a_in = a_pre_r;
      assign z_in = z_pre_r;
    end else begin : g_next
      assign x_in = x_r[i-1];
      assign y_in = y_r[i-1];
      assign a_in = a_r[i-1];
      assign z_in = z_r[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;

    always_ff @(posedge clk) begin
      z_r[i] <= z_in;
      if (!y_in[W-1]) begin
        x_r[i] <= x_in + dx;
        y_r[i] <= y_in - dy;
        a_r[i] <= a_in + rme_pkg::ATAN_Q30[i];
      end else begin
        x_r[i] <= x_in - dx;
        y_r[i] <= y_in + dy;
        a_r[i] <= a_in - rme_pkg::ATAN_Q30[i];
      end
    end
  end

  assign a_sum = a_r[STEPS-1] + rme_pkg::ROUND_Q30;
  assign q     = signed'(a_sum[AW-1:rme_pkg::ROUND_SHIFT]);

  always_comb begin
    if (q > LIM_Q) begin
      q_sat = LIM_Q;
    end else if (q < -LIM_Q) begin
      q_sat = -LIM_Q;
    end else begin
      q_sat = q;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= z_r[STEPS-1] ? '0 : q_sat[OW-1:0];
  end

  assign out_angle = out_r;

endmodule

>>> rtl/core/rotation_matrix_to_euler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_top
// z-y-x euler angles from seven entries of a q2.14 rotation matrix
// ----------------------------------------------------------------------------
// a request is taken at a rising edge where start is high and busy is low.
// busy stays low: the pipeline takes one request every cycle.
// each result shows for one cycle with out_valid high; results leave in
// request order, exactly one per request.
// from the accepting edge to the edge that takes the result a request passes
// through the input register, squaring, sum, one stage per root bit of the
// square root, operand select, quadrant fold, one stage per cordic step and
// the rounding stage.
// three cordic pipelines (roll, pitch, yaw) run side by side after the root.
// singular_threshold sits at byte address 0 of the apb port; the user must
// write it only while no request is in flight: the block does not enforce it.
// reset clears the valid bits of every stage and sets the threshold to 1;
// requests in flight are dropped. the receiver cannot stall the output.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_top #(
  parameter int CORDIC_STEPS = 16,
  parameter int ENTRY_WIDTH  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [ENTRY_WIDTH-1:0] in_r00,
  input  logic signed [ENTRY_WIDTH-1:0] in_r10,
  input  logic signed [ENTRY_WIDTH-1:0] in_r20,
  input  logic signed [ENTRY_WIDTH-1:0] in_r11,
  input  logic signed [ENTRY_WIDTH-1:0] in_r12,
  input  logic signed [ENTRY_WIDTH-1:0] in_r21,
  input  logic signed [ENTRY_WIDTH-1:0] in_r22,
  output logic                         out_valid,
  output logic signed [15:0]           out_roll_angle,
  output logic signed [14:0]           out_pitch_angle,
  output logic signed [15:0]           out_yaw_angle,
  output logic                         out_singular,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rme_pkg::ADDR_W-1:0]   paddr,
  input  logic [rme_pkg::DATA_W-1:0]   pwdata,
  output logic [rme_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  localparam int EW     = ENTRY_WIDTH;
  localparam int SW     = 2 * EW;
  localparam int SIDE_W = 7 * EW;
  localparam int IW     = EW + 2;
  localparam int CW     = (EW > rme_pkg::THR_W) ? EW : rme_pkg::THR_W;
  localparam int DLY    = CORDIC_STEPS + 2;

  // configuration
  logic                      cfg_wr;
  logic [rme_pkg::THR_W-1:0] thr_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == rme_pkg::ADDR_THRESHOLD) ?
                  {{(rme_pkg::DATA_W - rme_pkg::THR_W){1'b0}}, thr_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= rme_pkg::THR_RESET;
    end else if (cfg_wr && (paddr == rme_pkg::ADDR_THRESHOLD)) begin
      thr_r <= pwdata[rme_pkg::THR_W-1:0];
    end
  end

  // stage 1: input register
  logic              accept;
  logic              v1_r;
  logic [SIDE_W-1:0] side1_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      side1_r <= {in_r00, in_r10, in_r20, in_r11, in_r12, in_r21, in_r22};
    end
  end

  // stage 2: squares of the first column magnitudes
  logic signed [EW-1:0] s1_r00;
  logic signed [EW-1:0] s1_r10;
  logic [EW-1:0]        a0;
  logic [EW-1:0]        a1;
  logic                 v2_r;
  logic [SW-1:0]        sq0_r;
  logic [SW-1:0]        sq1_r;
  logic [SIDE_W-1:0]    side2_r;

  assign s1_r00 = signed'(side1_r[6*EW +: EW]);
  assign s1_r10 = signed'(side1_r[5*EW +: EW]);
  assign a0     = s1_r00[EW-1] ? EW'(-s1_r00) : EW'(s1_r00);
  assign a1     = s1_r10[EW-1] ? EW'(-s1_r10) : EW'(s1_r10);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    sq0_r   <= SW'(a0) * SW'(a0);
    sq1_r   <= SW'(a1) * SW'(a1);
    side2_r <= side1_r;
  end

  // stage 3: sum of squares
  logic              v3_r;
  logic [SW-1:0]     n_r;
  logic [SIDE_W-1:0] side3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= sq0_r + sq1_r;
    side3_r <= side2_r;
  end

  // square root
  logic              sq_v;
  logic [EW-1:0]     sq_root;
  logic [SIDE_W-1:0] sq_side;

  rme_isqrt #(
    .IN_W   (SW),
    .SIDE_W (SIDE_W)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_n      (n_r),
    .in_side   (side3_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // operand select
  logic signed [EW-1:0] q_r00;
  logic signed [EW-1:0] q_r10;
  logic signed [EW-1:0] q_r20;
  logic signed [EW-1:0] q_r11;
  logic signed [EW-1:0] q_r12;
  logic signed [EW-1:0] q_r21;
  logic signed [EW-1:0] q_r22;
  logic                 sing_nxt;

  assign q_r00 = signed'(sq_side[6*EW +: EW]);
  assign q_r10 = signed'(sq_side[5*EW +: EW]);
  assign q_r20 = signed'(sq_side[4*EW +: EW]);
  assign q_r11 = signed'(sq_side[3*EW +: EW]);
  assign q_r12 = signed'(sq_side[2*EW +: EW]);
  assign q_r21 = signed'(sq_side[1*EW +: EW]);
  assign q_r22 = signed'(sq_side[0 +: EW]);

  assign sing_nxt = (CW'(sq_root) < CW'(thr_r));

  logic                 v4_r;
  logic                 sing4_r;
  logic signed [IW-1:0] py4_r;
  logic signed [IW-1:0] px4_r;
  logic signed [IW-1:0] ry4_r;
  logic signed [IW-1:0] rx4_r;
  logic signed [IW-1:0] yy4_r;
  logic signed [IW-1:0] yx4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    sing4_r <= sing_nxt;
    py4_r   <= -IW'(q_r20);
    px4_r   <= signed'(IW'(sq_root));
    ry4_r   <= sing_nxt ? -IW'(q_r12) : IW'(q_r21);
    rx4_r   <= sing_nxt ? IW'(q_r11) : IW'(q_r22);
    yy4_r   <= IW'(q_r10);
    yx4_r   <= IW'(q_r00);
  end

  // angle pipelines
  rme_cordic #(
    .IW    (IW),
    .STEPS (CORDIC_STEPS),
    .OW    (16),
    .LIM   (rme_pkg::PI_Q13)
  ) u_roll (
    .clk           (clk),
    .in_y          (ry4_r),
    .in_x          (rx4_r),
    .in_force_zero (1'b0),
    .out_angle     (out_roll_angle)
  );

  rme_cordic #(
    .IW    (IW),
    .STEPS (CORDIC_STEPS),
    .OW    (15),
    .LIM   (rme_pkg::HALF_PI_Q13)
  ) u_pitch (
    .clk           (clk),
    .in_y          (py4_r),
    .in_x          (px4_r),
    .in_force_zero (1'b0),
    .out_angle     (out_pitch_angle)
  );

  rme_cordic #(
    .IW    (IW),
    .STEPS (CORDIC_STEPS),
    .OW    (16),
    .LIM   (rme_pkg::PI_Q13)
  ) u_yaw (
    .clk           (clk),
    .in_y          (yy4_r),
    .in_x          (yx4_r),
    .in_force_zero (sing4_r),
    .out_angle     (out_yaw_angle)
  );

  // valid and singular flag alongside the angle pipelines
  logic dv_r [DLY];
  logic ds_r [DLY];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DLY; k++) begin
        dv_r[k] <= 1'b0;
      end
    end else begin
      dv_r[0] <= v4_r;
      for (int k = 1; k < DLY; k++) begin
        dv_r[k] <= dv_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    ds_r[0] <= sing4_r;
    for (int k = 1; k < DLY; k++) begin
      ds_r[k] <= ds_r[k-1];
    end
  end

  assign out_valid    = dv_r[DLY-1];
  assign out_singular = ds_r[DLY-1];

endmodule

>>> rtl/core/rme_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_checker
// port-level checks on request latency, output ranges, yaw on singular results
// and register readback
module rme_checker #(
  parameter int CORDIC_STEPS = 16,
  parameter int ENTRY_WIDTH  = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic signed [15:0]            out_roll_angle,
  input logic signed [14:0]            out_pitch_angle,
  input logic signed [15:0]            out_yaw_angle,
  input logic                          out_singular,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [rme_pkg::ADDR_W-1:0]    paddr,
  input logic [rme_pkg::DATA_W-1:0]    pwdata,
  input logic [rme_pkg::DATA_W-1:0]    prdata,
  input logic                          pready
);

  localparam int LAT = ENTRY_WIDTH + CORDIC_STEPS + 6;

  logic accept;
  logic thr_wr;

  assign accept = start && !busy && rst_n;
  assign thr_wr = psel && penable && pwrite && pready &&
                  (paddr == rme_pkg::ADDR_THRESHOLD);

  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("request without result after pipeline latency");

  a_no_phantom : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result without matching request");

  a_yaw_singular : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_singular) |-> (out_yaw_angle == 16'sd0))
    else $error("yaw not zero on singular result");

  a_angle_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_pitch_angle <= rme_pkg::HALF_PI_Q13) &&
                   (out_pitch_angle >= -rme_pkg::HALF_PI_Q13) &&
                   (out_roll_angle <= rme_pkg::PI_Q13) &&
                   (out_roll_angle >= -rme_pkg::PI_Q13)))
    else $error("angle out of range");

  a_readback : assert property (@(posedge clk) disable iff (!rst_n)
    thr_wr |=> ((paddr != rme_pkg::ADDR_THRESHOLD) ||
                (prdata == {{(rme_pkg::DATA_W - rme_pkg::THR_W){1'b0}},
                            $past(pwdata[rme_pkg::THR_W-1:0])})))
    else $error("threshold readback mismatch");

endmodule

bind rotation_matrix_to_euler_top rme_checker #(
  .CORDIC_STEPS (CORDIC_STEPS),
  .ENTRY_WIDTH  (ENTRY_WIDTH)
) u_rme_checker (.*);

>>> tb/sv/rotation_matrix_to_euler_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_top_test
// self-checking bench for the rotation matrix to z-y-x euler angle pipeline
// ----------------------------------------------------------------------------
// matrices are sent on the start/busy command port with random gaps and
// back-to-back bursts. each request is predicted at its accepting edge by a
// fixed-point cordic model of the same rounding and saturation, and each
// out_valid result is compared field by field with the oldest prediction.
// the apb threshold register is written between phases when the pipeline
// has drained, read back, and set to 0, to 16384 and around the boundary of
// the singular case. stimulus mixes real rotation matrices, matrices near
// gimbal lock, in-range and full-width noise, and hand-picked corner cases.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_top_test;

  localparam int     STEP_COUNT  = 16;
  localparam int     LATENCY     = 16 + STEP_COUNT + 6;
  localparam int     STALL_LIMIT = 2000;
  localparam int     MAX_GAP     = 17;
  localparam longint QUARTER_Q30 = 64'sd1686629713;
  localparam longint PI_LIM      = 64'sd25736;
  localparam longint HALF_PI_LIM = 64'sd12868;

  typedef struct {
    logic signed [15:0] r00;
    logic signed [15:0] r10;
    logic signed [15:0] r20;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
  } matrix_t;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               singular;
  } euler_t;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic signed [15:0]            in_r00, in_r10, in_r20, in_r11, in_r12, in_r21, in_r22;
  logic                          out_valid;
  logic signed [15:0]            out_roll_angle;
  logic signed [14:0]            out_pitch_angle;
  logic signed [15:0]            out_yaw_angle;
  logic                          out_singular;
  logic                          psel, penable, pwrite;
  logic [rme_pkg::ADDR_W-1:0]    paddr;
  logic [rme_pkg::DATA_W-1:0]    pwdata;
  logic [rme_pkg::DATA_W-1:0]    prdata;
  logic                          pready;

  euler_t                        angle_q[$];
  logic [rme_pkg::THR_W-1:0]     thr_model;
  int                            error_count;
  int                            request_count;
  int                            result_count;
  int                            singular_count;
  int                            setting_count;
  int                            idle_cycles;

  rotation_matrix_to_euler_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_r00(in_r00), .in_r10(in_r10), .in_r20(in_r20), .in_r11(in_r11),
    .in_r12(in_r12), .in_r21(in_r21), .in_r22(in_r22),
    .out_valid(out_valid), .out_roll_angle(out_roll_angle),
    .out_pitch_angle(out_pitch_angle), .out_yaw_angle(out_yaw_angle),
    .out_singular(out_singular),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint atan_step_q30(int i);
    case (i)
      0:  return 843314856;
      1:  return 497837829;
      2:  return 263043836;
      3:  return 133525158;
      4:  return 67021686;
      5:  return 33543515;
      6:  return 16775850;
      7:  return 8388437;
      8:  return 4194282;
      9:  return 2097149;
      10: return 1048575;
      11: return 524287;
      12: return 262143;
      13: return 131071;
      14: return 65535;
      15: return 32767;
      default: return 0;
    endcase
  endfunction

  function automatic longint root_floor(longint n);
    longint r;
    longint t;
    int     b;
    r = 0;
    for (b = 17; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic longint cordic_angle(longint y_in, longint x_in, longint lim);
    longint x, y, a, t, dx, dy;
    int     i;
    if (x_in == 0 && y_in == 0) return 0;
    x = x_in * 16384;
    y = y_in * 16384;
    a = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; a = QUARTER_Q30;
      end else begin
        t = x; x = -y; y = t; a = -QUARTER_Q30;
      end
    end
    for (i = 0; i < STEP_COUNT; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; a = a + atan_step_q30(i);
      end else begin
        x = x - dx; y = y + dy; a = a - atan_step_q30(i);
      end
    end
    a = (a + 65536) >>> 17;
    if (a > lim) a = lim;
    if (a < -lim) a = -lim;
    return a;
  endfunction

  function automatic euler_t predict_euler(matrix_t m, logic [rme_pkg::THR_W-1:0] thr);
    euler_t e;
    longint a0, a1, sy, roll, pitch, yaw;
    a0 = longint'(m.r00);
    a1 = longint'(m.r10);
    if (a0 < 0) a0 = -a0;
    if (a1 < 0) a1 = -a1;
    sy = root_floor(a0 * a0 + a1 * a1);
    e.singular = (sy < longint'(thr));
    pitch = cordic_angle(-longint'(m.r20), sy, HALF_PI_LIM);
    if (!e.singular) begin
      roll = cordic_angle(longint'(m.r21), longint'(m.r22), PI_LIM);
      yaw  = cordic_angle(longint'(m.r10), longint'(m.r00), PI_LIM);
    end else begin
      roll = cordic_angle(-longint'(m.r12), longint'(m.r11), PI_LIM);
      yaw  = 0;
    end
    e.roll  = roll[15:0];
    e.pitch = pitch[14:0];
    e.yaw   = yaw[15:0];
    return e;
  endfunction

  // ------------------------------------------------------------ monitor/check

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  always @(posedge clk) begin : monitor
    euler_t want;
    if (!rst_n) begin
      thr_model   <= rme_pkg::THR_RESET;
      idle_cycles <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == rme_pkg::ADDR_THRESHOLD)
        thr_model <= pwdata[rme_pkg::THR_W-1:0];
      if (out_valid) begin
        result_count++;
        if (angle_q.size() == 0) begin
          report_mismatch("result with no request waiting");
        end else begin
          want = angle_q.pop_front();
          if (out_roll_angle !== want.roll)
            report_mismatch($sformatf("roll got %0d want %0d", out_roll_angle, want.roll));
          if (out_pitch_angle !== want.pitch)
            report_mismatch($sformatf("pitch got %0d want %0d", out_pitch_angle, want.pitch));
          if (out_yaw_angle !== want.yaw)
            report_mismatch($sformatf("yaw got %0d want %0d", out_yaw_angle, want.yaw));
          if (out_singular !== want.singular)
            report_mismatch($sformatf("singular got %b want %b", out_singular,
                                      want.singular));
        end
      end
      if (start && !busy) begin
        want = predict_euler('{in_r00, in_r10, in_r20, in_r11, in_r12, in_r21, in_r22},
                             thr_model);
        angle_q.push_back(want);
        request_count++;
        if (want.singular) singular_count++;
      end
      if ((start && !busy) || out_valid || (psel && penable)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("rotation_matrix_to_euler_top_test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_matrix(matrix_t m, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_r00 <= m.r00;
    in_r10 <= m.r10;
    in_r20 <= m.r20;
    in_r11 <= m.r11;
    in_r12 <= m.r12;
    in_r21 <= m.r21;
    in_r22 <= m.r22;
    start  <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic apb_access(bit wr, logic [rme_pkg::ADDR_W-1:0] addr,
                            logic [rme_pkg::DATA_W-1:0] wdata,
                            output logic [rme_pkg::DATA_W-1:0] rdata);
    bit done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdata = prdata;
      done  = (pready === 1'b1);
      @(posedge clk);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (angle_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_threshold(int thr);
    logic [rme_pkg::DATA_W-1:0] rd;
    wait_idle();
    apb_access(1'b1, rme_pkg::ADDR_THRESHOLD, rme_pkg::DATA_W'(thr), rd);
    apb_access(1'b0, rme_pkg::ADDR_THRESHOLD, '0, rd);
    if (rd[rme_pkg::THR_W-1:0] !== thr[rme_pkg::THR_W-1:0])
      report_mismatch($sformatf("threshold read %0d want %0d",
                                rd[rme_pkg::THR_W-1:0], thr));
    setting_count++;
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic matrix_t mk(int a00, int a10, int a20, int a11, int a12,
                                 int a21, int a22);
    matrix_t m;
    m.r00 = a00[15:0];
    m.r10 = a10[15:0];
    m.r20 = a20[15:0];
    m.r11 = a11[15:0];
    m.r12 = a12[15:0];
    m.r21 = a21[15:0];
    m.r22 = a22[15:0];
    return m;
  endfunction

  function automatic real unit_rand();
    return real'($urandom_range(0, 1000000)) / 1000000.0;
  endfunction

  function automatic int to_q14(real v, bit jitter);
    int k;
    k = $rtoi(v * 16384.0 + ((v >= 0.0) ? 0.5 : -0.5));
    if (jitter) k = k + int'($urandom_range(0, 6)) - 3;
    if (k > 16384) k = 16384;
    if (k < -16384) k = -16384;
    return k;
  endfunction

  function automatic matrix_t rotation_item(bit near_lock, bit jitter);
    real pi_r, ro, pt, yw, sr, cr, sp, cp, sz, cz;
    pi_r = 3.14159265358979;
    ro = (2.0 * unit_rand() - 1.0) * pi_r;
    yw = (2.0 * unit_rand() - 1.0) * pi_r;
    if (near_lock)
      pt = ((unit_rand() < 0.5) ? 1.0 : -1.0) * (pi_r / 2.0 - 0.05 * unit_rand());
    else
      pt = (2.0 * unit_rand() - 1.0) * pi_r / 2.0;
    sr = $sin(ro); cr = $cos(ro);
    sp = $sin(pt); cp = $cos(pt);
    sz = $sin(yw); cz = $cos(yw);
    return mk(to_q14(cz * cp, jitter), to_q14(sz * cp, jitter), to_q14(-sp, jitter),
              to_q14(sz * sp * sr + cz * cr, jitter), to_q14(sz * sp * cr - cz * sr, jitter),
              to_q14(cp * sr, jitter), to_q14(cp * cr, jitter));
  endfunction

  function automatic int noise_entry(int kind);
    case (kind)
      0:       return int'($urandom_range(0, 32768)) - 16384;
      1:       return int'(16'($urandom()));
      default: return int'($urandom_range(0, 16)) - 8;
    endcase
  endfunction

  function automatic matrix_t random_item();
    int pick;
    int kind;
    pick = $urandom_range(0, 99);
    if (pick < 45) return rotation_item(1'b0, $urandom_range(0, 3) == 0);
    if (pick < 65) return rotation_item(1'b1, $urandom_range(0, 3) == 0);
    kind = (pick < 80) ? 0 : (pick < 90) ? 1 : 2;
    return mk(noise_entry(kind), noise_entry(kind), noise_entry(kind), noise_entry(kind),
              noise_entry(kind), noise_entry(kind), noise_entry(kind));
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_register_access();
    logic [rme_pkg::DATA_W-1:0] rd;
    apb_access(1'b0, rme_pkg::ADDR_THRESHOLD, '0, rd);
    if (rd[rme_pkg::THR_W-1:0] !== rme_pkg::THR_RESET)
      report_mismatch($sformatf("threshold after reset %0d", rd[rme_pkg::THR_W-1:0]));
    set_threshold(0);
    set_threshold(16384);
    set_threshold(1);
  endtask

  task automatic test_special_matrices();
    send_matrix(mk(0, 0, 0, 0, 0, 0, 0), 1'b0);
    send_matrix(mk(16384, 0, 0, 16384, 0, 0, 16384), 1'b0);
    send_matrix(mk(16384, 16384, 16384, 16384, 16384, 16384, 16384), 1'b0);
    send_matrix(mk(-16384, -16384, -16384, -16384, -16384, -16384, -16384), 1'b1);
    send_matrix(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768), 1'b1);
    send_matrix(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767), 1'b0);
    send_matrix(mk(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555),
                1'b0);
    // angles at plus and minus pi
    send_matrix(mk(-16384, 0, 0, 0, 0, 0, -16384), 1'b1);
    send_matrix(mk(-16384, -1, 0, 0, 0, -1, -16384), 1'b1);
    // pitch at plus and minus half pi, gimbal lock
    send_matrix(mk(0, 0, -16384, 16384, 0, 0, 0), 1'b0);
    send_matrix(mk(0, 0, 16384, -1, 16384, 0, 0), 1'b0);
    send_matrix(mk(0, 0, 16384, 0, 0, 16384, 16384), 1'b0);
  endtask

  task automatic test_singular_boundary();
    set_threshold(16384);
    send_matrix(mk(16384, 0, 0, 16384, 0, 0, 16384), 1'b0);
    send_matrix(mk(16383, 0, 0, 16384, 0, 0, 16384), 1'b1);
    send_matrix(mk(11585, 11585, 0, 0, -16384, 16384, 0), 1'b0);
    send_matrix(mk(-16384, 0, 0, -16384, 0, 0, 16384), 1'b0);
    set_threshold(0);
    send_matrix(mk(0, 0, 0, 0, 0, 0, 0), 1'b0);
    send_matrix(mk(0, 0, -16384, 100, -200, 300, -400), 1'b0);
    set_threshold(5);
    send_matrix(mk(3, 4, 1, 2, 3, 4, 5), 1'b0);
    send_matrix(mk(3, -3, 1, 2, 3, 4, 5), 1'b1);
  endtask

  task automatic test_random_matrices();
    int thr_list[6];
    int p;
    int n;
    bit burst;
    thr_list = '{1, 0, 16384, 0, 11585, 3000};
    thr_list[3] = $urandom_range(0, 16384);
    burst = 1'b0;
    for (p = 0; p < 6; p++) begin
      set_threshold(thr_list[p]);
      for (n = 0; n < 280; n++) begin
        if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
        send_matrix(random_item(), burst);
      end
    end
  endtask

  initial begin
    error_count    = 0;
    request_count  = 0;
    result_count   = 0;
    singular_count = 0;
    setting_count  = 0;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_r00  <= '0; in_r10 <= '0; in_r20 <= '0; in_r11 <= '0;
    in_r12  <= '0; in_r21 <= '0; in_r22 <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_register_access();
    test_special_matrices();
    test_singular_boundary();
    test_random_matrices();

    wait_idle();
    repeat (LATENCY + 10) @(posedge clk);
    if (angle_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", angle_q.size()));
    $display("covered %0d requests and %0d results, %0d of them singular,",
             request_count, result_count, singular_count);
    $display("over %0d threshold settings with %0d mismatches", setting_count, error_count);
    if (error_count == 0) begin
      $display("rotation_matrix_to_euler_top_test passed");
    end else begin
      $display("rotation_matrix_to_euler_top_test failed");
    end
    $finish;
  end

endmodule
